@@ hdl/chtbl_pkg.sv @@
// ----------------------------------------------------------------------------
// chtbl_pkg
// Shared types and constants of the coalesced-chaining hash table: field
// widths, default table size, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package chtbl_pkg;

   // Fixed field widths of the item ports.
   localparam int KEY_W    = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;

   // Default number of slots in the table.
   localparam int TABLE_SIZE_DEF = 64;

   // Operation carried by an input item.
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_FIND   = 1'b1
   } op_type;

   // Status carried by a result item.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_WALK,
      S_WRLINK,
      S_DONE
   } state_type;

endpackage

@@ hdl/chtbl_ram.sv @@
// ----------------------------------------------------------------------------
// chtbl_ram
// Generic simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
module chtbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/chtbl_home.sv @@
// ----------------------------------------------------------------------------
// chtbl_home
// Home-slot unit: reduces the key magnitude modulo the table size with a
// multiplication by a scaled reciprocal and one correcting subtraction.
// ----------------------------------------------------------------------------
module chtbl_home
   import chtbl_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_W-1:0]              mag,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] home
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int RW    = IDX_W + 1;
   localparam int PW    = 2 * KEY_W;
   localparam logic [PW-1:0]    RECIP_WIDE = (PW'(1) << KEY_W) / PW'(TABLE_SIZE);
   localparam logic [KEY_W-1:0] RECIP      = RECIP_WIDE[KEY_W-1:0];
   localparam logic [RW-1:0]    TSZ        = RW'(TABLE_SIZE);

   logic             stg1_ff, stg1_in;
   logic             stg2_ff, stg2_in;
   logic             done_ff, done_in;
   logic [KEY_W-1:0] mag_ff, mag_in;
   logic [RW-1:0]    mag_lo_ff, mag_lo_in;
   logic [RW-1:0]    quo_lo_ff, quo_lo_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [PW-1:0]    prod;
   logic [2*RW-1:0]  back;
   logic [RW-1:0]    diff;

   // Quotient estimate: the high half of the magnitude times the reciprocal
   // of the table size. It is the true quotient or one less.
   assign prod = PW'(mag_ff) * PW'(RECIP);

   // The estimated remainder lies below twice the table size, so its low bits
   // alone give it exactly, and one compare and subtract finishes it.
   always_comb begin
      back = (2*RW)'(quo_lo_ff) * (2*RW)'(TSZ);
      diff = mag_lo_ff - back[RW-1:0];
      if (diff >= TSZ) begin
         diff = diff - TSZ;
      end
   end

   // Three-stage sequencing: latch the magnitude, multiply, correct.
   always_comb begin
      stg1_in   = start;
      stg2_in   = stg1_ff;
      done_in   = stg2_ff;
      mag_in    = start ? mag : mag_ff;
      mag_lo_in = mag_ff[RW-1:0];
      quo_lo_in = prod[KEY_W +: RW];
      rem_in    = stg2_ff ? diff[IDX_W-1:0] : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg1_ff <= 1'b0;
         stg2_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         stg1_ff <= stg1_in;
         stg2_ff <= stg2_in;
         done_ff <= done_in;
      end
      mag_ff    <= mag_in;
      mag_lo_ff <= mag_lo_in;
      quo_lo_ff <= quo_lo_in;
      rem_ff    <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

@@ hdl/coalesced_hash_table.sv @@
// ----------------------------------------------------------------------------
// coalesced_hash_table
// Coalesced-chaining hash table of signed 32-bit keys with insert and find.
// ----------------------------------------------------------------------------
// The table takes one item at a time. After reset it runs a clearing pass
// over every slot, during which req_stall stays high. An item then finds its
// home slot by latching the key magnitude, multiplying it by a scaled
// reciprocal of TABLE_SIZE and correcting the remainder. It then reads one
// slot per cycle on the chain or the linear probe, takes a link-write step
// when an insert links the chain tail to a new slot, a closing step when a
// full table or a walk of TABLE_SIZE links ends the item, and loads the
// result register once the previous result is no longer stalled. The next
// item is accepted while the previous result still waits to be taken.
module coalesced_hash_table
   import chtbl_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_op,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [SLOT_W-1:0]       rsp_slot_index
);

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int LINK_W  = $clog2(TABLE_SIZE + 1);
   localparam int PRB_W   = $clog2(TABLE_SIZE + 1);
   localparam int ENTRY_W = 1 + LINK_W + KEY_W;
   localparam logic [LINK_W-1:0] NO_LINK  = LINK_W'(TABLE_SIZE);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [PRB_W-1:0]  MAX_PRB  = PRB_W'(TABLE_SIZE);

   state_type        state_ff, state_in;
   logic             op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] home_ff, home_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [KEY_W-1:0] prev_key_ff, prev_key_in;
   logic             at_tail_ff, at_tail_in;
   logic [PRB_W-1:0] probes_ff, probes_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   status_type       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic               accept;
   logic [KEY_W-1:0]   req_mag;
   logic               home_done;
   logic [IDX_W-1:0]   home_slot;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic               d_used;
   logic [LINK_W-1:0]  d_link;
   logic [KEY_W-1:0]   d_key;
   logic               d_has_link;
   logic [IDX_W-1:0]   idx_next;
   logic [SLOT_W+IDX_W-1:0] slot_wide;

   assign accept  = req_valid && !req_stall;
   assign req_mag = req_key[KEY_W-1] ? (KEY_W'(0) - $unsigned(req_key)) : $unsigned(req_key);

   // Home-slot remainder unit.
   chtbl_home #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_home (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .mag  (req_mag),
      .done (home_done),
      .home (home_slot)
   );

   // Slot memory: one entry holds the used flag, the chain link and the key.
   chtbl_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_SIZE)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_in),
      .rd_data(rd_data)
   );

   // Fields of the entry read for the slot in idx_ff.
   assign d_used     = rd_data[ENTRY_W-1];
   assign d_link     = rd_data[KEY_W +: LINK_W];
   assign d_key      = rd_data[KEY_W-1:0];
   assign d_has_link = d_link < NO_LINK;
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : (idx_ff + IDX_W'(1));

   // Sequencer. Reads are issued with the next slot address, so the entry of
   // idx_ff is on rd_data in every walk cycle. Apart from the clearing pass,
   // writes happen only at the end of an item, before the next item's first
   // read, so no forwarding is needed.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      home_in       = home_ff;
      prev_in       = prev_ff;
      prev_key_in   = prev_key_ff;
      at_tail_in    = at_tail_ff;
      probes_in     = probes_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {1'b1, d_link, key_ff};

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {1'b0, NO_LINK, KEY_W'(0)};
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               key_in     = $unsigned(req_key);
               at_tail_in = 1'b0;
               probes_in  = '0;
               state_in   = S_HOME;
            end
         end

         S_HOME: begin
            if (home_done) begin
               idx_in   = home_slot;
               home_in  = home_slot;
               prev_in  = home_slot;
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            res_slot_in = '0;
            if (op_ff == OP_INSERT) begin
               if (probes_ff == MAX_PRB) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else if (!d_used) begin
                  // Store the key in the empty slot, keeping its link.
                  wr_en         = 1'b1;
                  res_status_in = ST_INSERTED;
                  res_slot_in   = idx_ff;
                  state_in      = (idx_ff != home_ff) ? S_WRLINK : S_DONE;
               end else if (d_key == key_ff) begin
                  res_status_in = ST_DUPLICATE;
                  state_in      = S_DONE;
               end else if (!at_tail_ff && d_has_link) begin
                  prev_in     = idx_ff;
                  prev_key_in = d_key;
                  idx_in      = d_link[IDX_W-1:0];
                  probes_in   = probes_ff + PRB_W'(1);
               end else begin
                  if (!at_tail_ff) begin
                     at_tail_in  = 1'b1;
                     prev_in     = idx_ff;
                     prev_key_in = d_key;
                  end
                  idx_in    = idx_next;
                  probes_in = probes_ff + PRB_W'(1);
               end
            end else begin
               if (probes_ff == MAX_PRB) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else if (d_used && d_key == key_ff) begin
                  res_status_in = ST_FOUND;
                  res_slot_in   = idx_ff;
                  state_in      = S_DONE;
               end else if (!d_used || !d_has_link) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else begin
                  idx_in    = d_link[IDX_W-1:0];
                  probes_in = probes_ff + PRB_W'(1);
               end
            end
         end

         S_WRLINK: begin
            // Link the last chain slot to the newly filled slot.
            wr_en    = 1'b1;
            wr_addr  = prev_ff;
            wr_data  = {1'b1, LINK_W'(idx_ff), prev_key_ff};
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register: loaded from the sequencer once the previous result
   // has been taken.
   assign slot_wide = {SLOT_W'(0), res_slot_ff};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = slot_wide[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      home_ff       <= home_in;
      prev_ff       <= prev_in;
      prev_key_ff   <= prev_key_in;
      at_tail_ff    <= at_tail_in;
      probes_ff     <= probes_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

@@ hdl/chtbl_checker.sv @@
// ----------------------------------------------------------------------------
// chtbl_checker
// Port-level checks of the hash table: result codes, slot field, one item
// at a time, no early result, a held stalled result. Bound to the top level.
// ----------------------------------------------------------------------------
module chtbl_checker
   import chtbl_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [SLOT_W-1:0]       rsp_slot_index
);

   // A result carries one of the five defined status codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_INSERTED || rsp_status == ST_DUPLICATE ||
                     rsp_status == ST_FULL || rsp_status == ST_FOUND ||
                     rsp_status == ST_NOT_FOUND))
      else $error("result item carries an undefined status");

   // Only inserted and found results name a slot.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_INSERTED && rsp_status != ST_FOUND)
         |-> rsp_slot_index == '0)
      else $error("slot index not zero on a miss, duplicate or full result");

   // The table works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("a second item was accepted while one is in progress");

   // No result can appear in the cycle right after an item is taken.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result item appeared too early");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index)))
      else $error("stalled result item changed");

endmodule

bind coalesced_hash_table chtbl_checker u_chtbl_checker (.*);

@@ tb/tb_coalesced_hash_table.sv @@
// ----------------------------------------------------------------------------
// tb_coalesced_hash_table
// Self-checking bench for the coalesced-chaining hash table. A directed burst
// builds coalesced chains, wraps the linear probe and hits the extreme keys.
// Random inserts and finds then fill the table to full and keep looking up
// keys. A shadow table predicts every result, and the results are checked in
// order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_coalesced_hash_table;
   timeunit 1ns;
   timeprecision 1ps;
   import chtbl_pkg::*;

   localparam int NSLOT        = TABLE_SIZE_DEF;
   localparam int RANDOM_ITEMS = 1130;
   localparam int MAX_WAIT     = 16;
   localparam int REPORT_MAX   = 10;
   localparam int DRAIN_CYCLES = NSLOT + 40;
   localparam int CYCLE_LIMIT  = 1_000_000;

   typedef struct {
      op_type           op;
      logic [KEY_W-1:0] key;
   } hash_req_type;

   typedef struct {
      op_type            op;
      logic [KEY_W-1:0]  key;
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } hash_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = 1'b0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [SLOT_W-1:0]       rsp_slot_index;

   // Shadow copy of the slot store.
   logic [KEY_W-1:0] shadow_key  [NSLOT];
   bit               shadow_used [NSLOT];
   int unsigned      shadow_next [NSLOT];

   hash_req_type     pending_reqs[$];
   hash_rsp_type     table_results[$];
   logic [KEY_W-1:0] known_keys[$];

   int          total_items = 0;
   int          accepted_items = 0;
   int          fail_count = 0;
   int          req_wait = 0;
   int          rsp_hold = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int unsigned cycle_count = 0;

   coalesced_hash_table #(
      .TABLE_SIZE(NSLOT)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

   // Clock with a 2 ns period.
   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Home slot: magnitude of the key taken as unsigned, modulo the table size.
   function automatic int unsigned home_slot(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] mag;
      mag = k[KEY_W-1] ? (32'd0 - k) : k;
      return mag % NSLOT;
   endfunction

   // Apply one insert or find to the shadow table and return its result.
   function automatic hash_rsp_type hash_apply(op_type op, logic [KEY_W-1:0] k);
      hash_rsp_type r;
      int unsigned  home;
      int unsigned  idx;
      int unsigned  prev;
      int unsigned  probes;
      bit           at_tail;
      bit           done;
      home    = home_slot(k);
      idx     = home;
      prev    = home;
      probes  = 0;
      at_tail = 1'b0;
      done    = 1'b0;
      r.op    = op;
      r.key   = k;
      r.slot  = '0;
      if (op == OP_INSERT) begin
         r.status = ST_INSERTED;
         // Walk the chain to its tail, then probe linearly for an empty slot.
         while (!done && probes < NSLOT && shadow_used[idx]) begin
            if (shadow_key[idx] == k) begin
               r.status = ST_DUPLICATE;
               done     = 1'b1;
            end else begin
               if (!at_tail && shadow_next[idx] < NSLOT) begin
                  prev = idx;
                  idx  = shadow_next[idx];
               end else begin
                  if (!at_tail) begin
                     at_tail = 1'b1;
                     prev    = idx;
                  end
                  idx = (idx + 1) % NSLOT;
               end
               probes++;
            end
         end
         if (!done) begin
            if (probes >= NSLOT) begin
               r.status = ST_FULL;
            end else begin
               shadow_key[idx]  = k;
               shadow_used[idx] = 1'b1;
               if (idx != home) begin
                  shadow_next[prev] = idx;
               end
               r.slot = idx[SLOT_W-1:0];
            end
         end
      end else begin
         r.status = ST_NOT_FOUND;
         // Follow links from home until the key, an empty slot or the chain end.
         for (int unsigned n = 0; n < NSLOT && !done; n++) begin
            if (shadow_used[idx] && shadow_key[idx] == k) begin
               r.status = ST_FOUND;
               r.slot   = idx[SLOT_W-1:0];
               done     = 1'b1;
            end else if (!shadow_used[idx] || shadow_next[idx] >= NSLOT) begin
               done = 1'b1;
            end else begin
               idx = shadow_next[idx];
            end
         end
      end
      return r;
   endfunction

   // Wait before the next item: random, with occasional stretches of none.
   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 23) == 0) begin
         calm = ~calm;
      end
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2: v = $urandom_range(0, 600) - 300;
         3: begin
            // Keys that share a few home slots build long coalesced chains.
            v = $urandom_range(0, 40) * NSLOT + $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 1) begin
               v = 32'd0 - v;
            end
         end
         4: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = '1;
               default: v = '0;
            endcase
         end
         default: v = $urandom_range(0, 255);
      endcase
      return v;
   endfunction

   function automatic void add_item(op_type op, logic [KEY_W-1:0] k);
      hash_req_type r;
      r.op  = op;
      r.key = k;
      pending_reqs.push_back(r);
      if (op == OP_INSERT) begin
         known_keys.push_back(k);
      end
   endfunction

   // Driver: present the next item after its wait; predict on acceptance.
   always @(posedge clock) begin
      hash_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            table_results.push_back(hash_apply(op_type'(req_op), req_key));
            accepted_items++;
            req_wait = draw_wait(req_calm);
         end
         if (!req_valid || !req_stall) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_op    <= nxt.op;
               req_key   <= nxt.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random and check each result against the oldest
   // prediction.
   always @(posedge clock) begin
      hash_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (table_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("unexpected result: status %0d slot %0d",
                           rsp_status, rsp_slot_index);
               end
            end else begin
               exp_rsp = table_results.pop_front();
               if (rsp_status !== exp_rsp.status || rsp_slot_index !== exp_rsp.slot)
               begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("mismatch on %s of key %0d: expected %s slot %0d, got %0d slot %0d",
                              exp_rsp.op.name(), $signed(exp_rsp.key),
                              exp_rsp.status.name(), exp_rsp.slot,
                              rsp_status, rsp_slot_index);
                  end
               end
            end
            rsp_hold = draw_wait(rsp_calm);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // Timeout guard.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Stimulus, reset and end of run.
   initial begin
      op_type           op;
      logic [KEY_W-1:0] k;
      for (int s = 0; s < NSLOT; s++) begin
         shadow_key[s]  = '0;
         shadow_used[s] = 1'b0;
         shadow_next[s] = NSLOT;
      end

      // Directed: one chain at home zero, a coalesced chain that joins it,
      // a probe that wraps past the end, the extreme keys and duplicates.
      add_item(OP_FIND,   32'd0);
      add_item(OP_INSERT, 32'd0);
      add_item(OP_FIND,   32'd0);
      add_item(OP_INSERT, 32'd64);
      add_item(OP_INSERT, -32'd64);
      add_item(OP_INSERT, 32'h8000_0000);
      add_item(OP_FIND,   32'h8000_0000);
      add_item(OP_INSERT, 32'h7FFF_FFFF);
      add_item(OP_INSERT, 32'hFFFF_FFFF);
      add_item(OP_INSERT, 32'd127);
      add_item(OP_INSERT, 32'h8000_0001);
      add_item(OP_INSERT, 32'd64);
      add_item(OP_INSERT, 32'h8000_0000);
      add_item(OP_FIND,   32'hFFFF_FFFF);
      add_item(OP_FIND,   32'd127);
      add_item(OP_FIND,   32'h7FFF_FFFF);
      add_item(OP_FIND,   32'h8000_0001);
      add_item(OP_FIND,   32'd128);
      add_item(OP_FIND,   32'd5);
      add_item(OP_FIND,   -32'd64);

      // Random: mostly finds of known keys; inserts fill the table to full.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            op = OP_INSERT;
            k  = ($urandom_range(0, 4) == 0) ?
                 known_keys[$urandom_range(0, known_keys.size() - 1)] : fresh_key();
         end else begin
            op = OP_FIND;
            k  = ($urandom_range(0, 4) < 3) ?
                 known_keys[$urandom_range(0, known_keys.size() - 1)] : fresh_key();
         end
         add_item(op, k);
      end
      total_items = pending_reqs.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < total_items) @(posedge clock);
      while (table_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && table_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
